[rtl/core/rae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_pkg
// Shared opcodes, status bit positions and types for the register ALU
// execute block.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned StatusW = 5;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned RegIdxW = 2;

  // Opcodes.
  localparam logic [4:0] OP_LOAD    = 5'd0;
  localparam logic [4:0] OP_STORE   = 5'd1;
  localparam logic [4:0] OP_ADD     = 5'd2;
  localparam logic [4:0] OP_ADDC    = 5'd3;
  localparam logic [4:0] OP_SUB     = 5'd4;
  localparam logic [4:0] OP_SUBC    = 5'd5;
  localparam logic [4:0] OP_AND     = 5'd6;
  localparam logic [4:0] OP_XOR     = 5'd7;
  localparam logic [4:0] OP_COMPL   = 5'd8;
  localparam logic [4:0] OP_SHL     = 5'd9;
  localparam logic [4:0] OP_SHLA    = 5'd10;
  localparam logic [4:0] OP_SHR     = 5'd11;
  localparam logic [4:0] OP_SHRA    = 5'd12;
  localparam logic [4:0] OP_COMPARE = 5'd13;
  localparam logic [4:0] OP_GETSTAT = 5'd14;
  localparam logic [4:0] OP_PUTSTAT = 5'd15;
  // Jumps, call, return, I/O and halt occupy this range.
  localparam logic [4:0] OP_XFER_LO = 5'd16;
  localparam logic [4:0] OP_XFER_HI = 5'd24;
  localparam logic [4:0] OP_NOOP    = 5'd25;

  // Status bit positions.
  localparam int unsigned ST_C = 0;
  localparam int unsigned ST_G = 1;
  localparam int unsigned ST_E = 2;
  localparam int unsigned ST_L = 3;
  localparam int unsigned ST_V = 4;

  typedef enum logic [1:0] {
    OUT_EXEC      = 2'd0,
    OUT_UNHANDLED = 2'd1,
    OUT_INVALID   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic                 wr_en;
    logic [DataW-1:0]     value;
    logic [StatusW-1:0]   status;
    outcome_e             outcome;
  } rae_result_t;

endpackage

[rtl/core/rae_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_alu
// Combinational decode and execute of one instruction word against the
// destination and source register values and the current status.
// ----------------------------------------------------------------------------
module rae_alu (
  input  logic [15:0]                  instr_i,
  input  logic [rae_pkg::DataW-1:0]    rd_val_i,
  input  logic [rae_pkg::DataW-1:0]    rs_val_i,
  input  logic [rae_pkg::StatusW-1:0]  status_i,
  output rae_pkg::rae_result_t         result_o
);
  import rae_pkg::*;

  logic [4:0]       op;
  logic             imm_flag;
  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic             cin;
  logic [DataW:0]   a17;
  logic [DataW:0]   b17;
  logic [DataW:0]   cin17;
  logic [DataW:0]   sum;
  logic [DataW:0]   sum_c;
  logic [DataW:0]   diff;
  logic [DataW:0]   diff_c;
  logic             lt;
  logic             eq;

  assign op       = instr_i[15:11];
  assign imm_flag = instr_i[8];
  assign a        = rd_val_i;
  assign b        = imm_flag ? {{8{instr_i[7]}}, instr_i[7:0]} : rs_val_i;
  assign cin      = status_i[ST_C];

  // Seventeen bits of the sign-extended operands carry everything needed
  // for the carry flag, which is bit 16 of the extended result.
  assign a17    = {a[DataW-1], a};
  assign b17    = {b[DataW-1], b};
  assign cin17  = {{DataW{1'b0}}, cin};
  assign sum    = a17 + b17;
  assign sum_c  = a17 + b17 + cin17;
  assign diff   = a17 - b17;
  assign diff_c = a17 - b17 - cin17;

  assign lt = $signed(a) < $signed(b);
  assign eq = (a == b);

  always_comb begin
    result_o.value   = a;
    result_o.status  = status_i;
    result_o.outcome = OUT_EXEC;
    unique case (op)
      OP_LOAD: begin
        if (imm_flag) begin
          result_o.value = b;
        end else begin
          result_o.outcome = OUT_UNHANDLED;
        end
      end
      OP_STORE: begin
        result_o.outcome = OUT_UNHANDLED;
      end
      OP_ADD: begin
        result_o.value        = sum[DataW-1:0];
        result_o.status[ST_C] = sum[DataW];
        result_o.status[ST_V] = (a[DataW-1] == b[DataW-1]) &&
                                (sum[DataW-1] != a[DataW-1]);
      end
      OP_ADDC: begin
        result_o.value        = sum_c[DataW-1:0];
        result_o.status[ST_C] = sum_c[DataW];
      end
      OP_SUB: begin
        result_o.value        = diff[DataW-1:0];
        result_o.status[ST_C] = diff[DataW];
        result_o.status[ST_V] = (a[DataW-1] != b[DataW-1]) &&
                                (diff[DataW-1] != a[DataW-1]);
      end
      OP_SUBC: begin
        result_o.value        = diff_c[DataW-1:0];
        result_o.status[ST_C] = diff_c[DataW];
      end
      OP_AND: begin
        result_o.value = a & b;
      end
      OP_XOR: begin
        result_o.value = a ^ b;
      end
      OP_COMPL: begin
        result_o.value = ~a;
      end
      OP_SHL: begin
        result_o.value        = {a[DataW-2:0], 1'b0};
        result_o.status[ST_C] = a[DataW-1];
      end
      OP_SHLA: begin
        result_o.value        = {a[DataW-1], a[DataW-3:0], 1'b0};
        result_o.status[ST_C] = a[DataW-1];
      end
      OP_SHR: begin
        result_o.value        = {1'b0, a[DataW-1:1]};
        result_o.status[ST_C] = a[0];
      end
      OP_SHRA: begin
        result_o.value        = {a[DataW-1], a[DataW-1:1]};
        result_o.status[ST_C] = a[0];
      end
      OP_COMPARE: begin
        result_o.status[ST_L] = lt;
        result_o.status[ST_E] = eq;
        result_o.status[ST_G] = !lt && !eq;
      end
      OP_GETSTAT: begin
        result_o.value = {{(DataW-StatusW){1'b0}}, status_i};
      end
      OP_PUTSTAT: begin
        result_o.status = a[StatusW-1:0];
      end
      OP_NOOP: begin
        result_o.value = a;
      end
      default: begin
        if (op >= OP_XFER_LO && op <= OP_XFER_HI) begin
          result_o.outcome = OUT_UNHANDLED;
        end else begin
          result_o.outcome = OUT_INVALID;
        end
      end
    endcase
    result_o.wr_en = (result_o.outcome == OUT_EXEC);
    if (!result_o.wr_en) begin
      result_o.value  = a;
      result_o.status = status_i;
    end
  end

endmodule

[rtl/core/register_alu_execute_16bit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_alu_execute_16bit
// Execute stage of a small register machine with four 16-bit registers and
// a 5-bit status word.
// ----------------------------------------------------------------------------
// An instruction transaction is registered on acceptance and executed once the
// output register can take its result, when the register file and status are
// written back and the result lands in the output register. One instruction is
// accepted every cycle as long as results are taken; the rate is set by the
// register-file and status writeback, which lets each instruction see the
// state left by the one before it. Registers and status reset to zero.
module register_alu_execute_16bit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [15:0]                instr_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         dest_value_o,
  output logic [4:0]                 status_flags_o,
  output logic [1:0]                 outcome_o
);
  import rae_pkg::*;

  logic                  s1_valid_q;
  logic [15:0]           instr_q;
  logic                  out_valid_q;
  logic [DataW-1:0]      dest_value_q;
  logic [StatusW-1:0]    status_flags_q;
  outcome_e              outcome_q;
  logic [DataW-1:0]      reg_file_q [NumRegs];
  logic [StatusW-1:0]    status_q;
  logic                  s1_advance;
  logic                  in_accept;
  logic [RegIdxW-1:0]    rd_idx;
  logic [RegIdxW-1:0]    rs_idx;
  rae_result_t           result;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  assign rd_idx = instr_q[10:9];
  assign rs_idx = instr_q[7:6];

  rae_alu u_alu (
    .instr_i  (instr_q),
    .rd_val_i (reg_file_q[rd_idx]),
    .rs_val_i (reg_file_q[rs_idx]),
    .status_i (status_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      for (int i = 0; i < NumRegs; i++) begin
        reg_file_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
        status_q    <= result.status;
        if (result.wr_en) begin
          reg_file_q[rd_idx] <= result.value;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q <= instr_i;
    end
    if (s1_advance) begin
      dest_value_q   <= result.value;
      status_flags_q <= result.status;
      outcome_q      <= result.outcome;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_value_o   = $signed(dest_value_q);
  assign status_flags_o = status_flags_q;
  assign outcome_o      = outcome_q;

endmodule

[rtl/core/rae_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_checker
// Port-level checks for the register ALU execute block, bound to its top.
// ----------------------------------------------------------------------------
module rae_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] dest_value_o,
  input logic [4:0]         status_flags_o,
  input logic [1:0]         outcome_o
);
  import rae_pkg::*;

  // A waiting result transaction is never withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(dest_value_o) && $stable(status_flags_o) && $stable(outcome_o))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OUT_EXEC || outcome_o == OUT_UNHANDLED ||
                     outcome_o == OUT_INVALID))
    else $error("unknown outcome code");

  // With the output register empty the input stage always drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // An instruction accepted while the output register is empty yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted instruction produced no result");

endmodule

bind register_alu_execute_16bit rae_checker u_rae_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for register_alu_execute_16bit. A predictor keeps
// its own register file and status word, works out the result of every
// accepted instruction and checks it against the block output in order.
// Directed tests cover the arithmetic extremes, every opcode and the status
// moves. A long random test follows, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;
  import rae_pkg::*;

  localparam logic [4:0] OP_LAST      = 5'd31;
  localparam int unsigned RandomInstrs = 1400;
  localparam int unsigned MaxReports   = 50;

  typedef struct packed {
    logic [DataW-1:0]   value;
    logic [StatusW-1:0] status;
    outcome_e           outcome;
  } exec_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [15:0]       instr_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [15:0] dest_value_o;
  logic [4:0]        status_flags_o;
  logic [1:0]        outcome_o;

  // Architectural state as the predictor sees it.
  logic [DataW-1:0]   arch_regs [NumRegs];
  logic [StatusW-1:0] arch_status;

  exec_result_t pending_results [$];
  int unsigned  fail_count = 0;
  int unsigned  burst_left = 0;
  logic [7:0]   sink_cycle = '0;

  register_alu_execute_16bit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .instr_i        (instr_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_value_o   (dest_value_o),
    .status_flags_o (status_flags_o),
    .outcome_o      (outcome_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Executes one instruction against the predicted state and returns what the
  // block should report for it.
  function automatic exec_result_t execute_instr(input logic [15:0] w);
    logic [4:0]   op;
    logic [1:0]   rd;
    logic [1:0]   rs;
    logic         immf;
    logic         cin;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  res;
    exec_result_t r;
    op   = w[15:11];
    rd   = w[10:9];
    immf = w[8];
    rs   = w[7:6];
    a    = {{16{arch_regs[rd][15]}}, arch_regs[rd]};
    b    = immf ? {{24{w[7]}}, w[7:0]} : {{16{arch_regs[rs][15]}}, arch_regs[rs]};
    cin  = arch_status[ST_C];
    res  = a;
    r.outcome = OUT_EXEC;
    case (op)
      OP_LOAD: begin
        if (immf) res = b;
        else r.outcome = OUT_UNHANDLED;
      end
      OP_ADD: begin
        res = a + b;
        arch_status[ST_C] = res[16];
        arch_status[ST_V] = (a[15] == b[15]) && (res[15] != a[15]);
      end
      OP_ADDC: begin
        res = a + b + {31'b0, cin};
        arch_status[ST_C] = res[16];
      end
      OP_SUB: begin
        res = a - b;
        arch_status[ST_C] = res[16];
        arch_status[ST_V] = (a[15] != b[15]) && (res[15] != a[15]);
      end
      OP_SUBC: begin
        res = a - b - {31'b0, cin};
        arch_status[ST_C] = res[16];
      end
      OP_AND:   res = a & b;
      OP_XOR:   res = a ^ b;
      OP_COMPL: res = ~a;
      OP_SHL: begin
        res = a << 1;
        arch_status[ST_C] = res[16];
      end
      OP_SHLA: begin
        res = {16'b0, a[15], a[13:0], 1'b0};
        arch_status[ST_C] = a[15];
      end
      OP_SHR: begin
        res = {17'b0, a[15:1]};
        arch_status[ST_C] = a[0];
      end
      OP_SHRA: begin
        res = {16'b0, a[15], a[15:1]};
        arch_status[ST_C] = a[0];
      end
      OP_COMPARE: begin
        arch_status[ST_L] = $signed(a) < $signed(b);
        arch_status[ST_E] = a == b;
        arch_status[ST_G] = $signed(a) > $signed(b);
      end
      OP_GETSTAT: res = {27'b0, arch_status};
      OP_PUTSTAT: arch_status = arch_regs[rd][StatusW-1:0];
      OP_NOOP: ;
      default: begin
        if (op == OP_STORE || (op >= OP_XFER_LO && op <= OP_XFER_HI)) begin
          r.outcome = OUT_UNHANDLED;
        end else begin
          r.outcome = OUT_INVALID;
        end
      end
    endcase
    if (r.outcome == OUT_EXEC) arch_regs[rd] = res[15:0];
    r.value  = arch_regs[rd];
    r.status = arch_status;
    return r;
  endfunction

  function automatic logic [15:0] enc_reg(input logic [4:0] op, input logic [1:0] rd,
                                          input logic [1:0] rs);
    return {op, rd, 1'b0, rs, 6'b0};
  endfunction

  function automatic logic [15:0] enc_imm(input logic [4:0] op, input logic [1:0] rd,
                                          input logic [7:0] imm);
    return {op, rd, 1'b1, imm};
  endfunction

  function automatic void report_mismatch(input string what, input int unsigned exp_v,
                                          input int unsigned act_v);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endfunction

  // Predict on every input transaction and check every output transaction.
  always @(posedge clk_i) begin
    exec_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) pending_results.push_back(execute_instr(instr_i));
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, value", 0, dest_value_o);
        end else begin
          exp_r = pending_results.pop_front();
          if (dest_value_o !== exp_r.value)
            report_mismatch("dest_value", exp_r.value, dest_value_o);
          if (status_flags_o !== exp_r.status)
            report_mismatch("status_flags", exp_r.status, status_flags_o);
          if (outcome_o !== exp_r.outcome)
            report_mismatch("outcome", exp_r.outcome, outcome_o);
        end
      end
    end
  end

  // The sink cycles through four stall patterns in turn.
  always @(posedge clk_i) begin
    sink_cycle <= sink_cycle + 8'd1;
    case (sink_cycle[7:6])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= (sink_cycle[1:0] == 2'd0);
      default: out_ready_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Sends one instruction; the sender works in bursts with random gaps.
  task automatic send_instr(input logic [15:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    instr_i    <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic test_after_reset();
    send_instr(enc_reg(OP_GETSTAT, 2'd0, 2'd0));
    send_instr(enc_reg(OP_ADD, 2'd1, 2'd2));
  endtask

  task automatic test_arith_extremes();
    send_instr(enc_imm(OP_LOAD, 2'd0, 8'h7f));
    send_instr(enc_imm(OP_LOAD, 2'd1, 8'h80));
    send_instr(enc_imm(OP_LOAD, 2'd2, 8'hff));
    send_instr(enc_reg(OP_SHR, 2'd2, 2'd0));
    // 0x7fff + 1 overflows into the most negative value.
    send_instr(enc_imm(OP_ADD, 2'd2, 8'h01));
    send_instr(enc_imm(OP_LOAD, 2'd3, 8'h00));
    send_instr(enc_reg(OP_SUB, 2'd3, 2'd2));
    send_instr(enc_reg(OP_ADD, 2'd2, 2'd3));
    send_instr(enc_imm(OP_ADDC, 2'd0, 8'h7f));
    send_instr(enc_imm(OP_SUBC, 2'd1, 8'h7f));
  endtask

  task automatic test_logic_and_shifts();
    send_instr(enc_reg(OP_AND, 2'd0, 2'd1));
    send_instr(enc_imm(OP_XOR, 2'd1, 8'hff));
    send_instr(enc_reg(OP_COMPL, 2'd3, 2'd0));
    send_instr(enc_reg(OP_SHL, 2'd0, 2'd0));
    send_instr(enc_reg(OP_SHLA, 2'd3, 2'd0));
    send_instr(enc_reg(OP_SHRA, 2'd3, 2'd0));
    send_instr(enc_reg(OP_COMPARE, 2'd0, 2'd3));
    send_instr(enc_reg(OP_COMPARE, 2'd3, 2'd0));
  endtask

  task automatic test_status_moves();
    send_instr(enc_imm(OP_LOAD, 2'd0, 8'h1f));
    send_instr(enc_reg(OP_PUTSTAT, 2'd0, 2'd0));
    send_instr(enc_reg(OP_GETSTAT, 2'd3, 2'd0));
    send_instr(enc_reg(OP_NOOP, 2'd1, 2'd0));
  endtask

  task automatic test_unhandled_ops();
    send_instr(enc_reg(OP_LOAD, 2'd1, 2'd2));
    send_instr(enc_reg(OP_STORE, 2'd2, 2'd1));
    send_instr(enc_imm(OP_XFER_LO, 2'd3, 8'hff));
    send_instr(enc_imm(OP_XFER_HI, 2'd0, 8'h00));
    send_instr(enc_reg(OP_NOOP + 5'd1, 2'd1, 2'd3));
    send_instr(enc_imm(OP_LAST, 2'd2, 8'h55));
  endtask

  // Mostly executable opcodes with random operands, plus a share of the
  // left-out and invalid ranges.
  task automatic test_random_stream();
    int unsigned pick;
    logic [4:0]  op;
    logic [10:0] body;
    repeat (RandomInstrs) begin
      pick = $urandom_range(0, 99);
      body = 11'($urandom_range(0, 2047));
      if (pick < 5) begin
        op = 5'($urandom_range(OP_NOOP + 5'd1, OP_LAST));
      end else if (pick < 12) begin
        op = 5'($urandom_range(OP_XFER_LO - 5'd1, OP_XFER_HI));
        if (op < OP_XFER_LO) op = OP_STORE;
      end else begin
        op = 5'($urandom_range(OP_LOAD, OP_PUTSTAT + 5'd1));
        if (op > OP_PUTSTAT) op = OP_NOOP;
        // Most loads carry an immediate so that registers keep changing.
        if (op == OP_LOAD && $urandom_range(0, 4) != 0) body[8] = 1'b1;
      end
      send_instr({op, body});
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) arch_regs[i] = '0;
    arch_status = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_arith_extremes();
    test_logic_and_shifts();
    test_status_moves();
    test_unhandled_ops();
    test_random_stream();
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
